@@ rtl/dc_pkg.sv @@
package dc_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int LAB_W      = 7;
	localparam int EPS_W      = 15;
	localparam int MINP_W     = 7;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;
	localparam int LAT        = 2;
	localparam int PASS_W     = $clog2(MAX_POINTS + LAT + 1);
	localparam int SQ_W       = 2 * COORD_BITS;
	localparam int EPSQ_W     = 2 * EPS_W;
	localparam int CMP_W      = (COORD_BITS > EPS_W) ? COORD_BITS : EPS_W;
	localparam int SUM_W      = ((SQ_W > EPSQ_W) ? SQ_W : EPSQ_W) + 1;
	localparam int CMPN_W     = ((CNT_W > MINP_W) ? CNT_W : MINP_W) + 1;

	localparam logic [LAB_W-1:0] NOISE_LAB  = '1;
	localparam logic [LAB_W-1:0] UNSEEN_LAB = '0;

	localparam logic REG_EPSILON = 1'b0;
	localparam logic REG_MINPTS  = 1'b1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [LAB_W-1:0]             lab;
		logic                         qm;
	} cell_t;

	typedef struct packed {
		logic             set_lab;
		logic [LAB_W-1:0] lab;
		logic             set_qm;
	} cell_mod_t;

	typedef struct packed {
		logic                         elig;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic signed [COORD_BITS-1:0] hx;
		logic signed [COORD_BITS-1:0] hy;
		logic [IDX_W-1:0]             k;
	} dist_req_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] k;
	} dist_res_t;

endpackage

@@ rtl/dc_if.sv @@
interface dc_point_if;
	import dc_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic                         final_point;
	modport source(output valid, coord_x, coord_y, final_point, input ready);
	modport sink(input valid, coord_x, coord_y, final_point, output ready);
endinterface

interface dc_label_if;
	import dc_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] point_index;
	logic [LAB_W-1:0] cluster_label;
	logic [LAB_W-1:0] cluster_total;
	logic             final_label;
	modport source(output valid, point_index, cluster_label, cluster_total, final_label,
		input ready);
	modport sink(input valid, point_index, cluster_label, cluster_total, final_label,
		output ready);
endinterface

@@ rtl/density_clustering.sv @@
// density clustering of 2-D points (dbscan)
// points channel: one point word per cycle while loading; final_point = 1 on
// the last word starts clustering and points.ready stays low until all labels
// are out. words beyond the store depth are dropped, final_point still counts.
// labels channel: one word per loaded point in load order, with the label
// (0 = noise), the number of clusters and final_label on the last word.
// apb port: epsilon at 0x0, minimum neighbor count at 0x4; write only while idle.
// points sit in a ring of cells that rotates one step per cycle while
// clustering; one distance pipeline looks at the head cell.
// each neighbor scan sweeps the ring past the head cell and drains the
// distance pipeline; each lookup of a point rotates the ring until that
// point is at the head cell.
// a receiver stall holds the ring; the block then waits, nothing is lost.
// reset clears labels, counts and the registers to epsilon 30, minimum count 10;
// after emission the block returns to loading with the registers kept.
module density_clustering (
	input  logic                          clk,
	input  logic                          arst_n,
	dc_point_if.sink                      points,
	dc_label_if.source                    labels,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dc_pkg::ADDR_W-1:0]     paddr,
	input  logic [dc_pkg::DATA_W-1:0]     pwdata,
	output logic [dc_pkg::DATA_W-1:0]     prdata,
	output logic                          pready
);
	import dc_pkg::*;

	typedef enum logic [7:0] {
		S_LOAD   = 8'b0000_0001,
		S_SEEK_I = 8'b0000_0010,
		S_PASS   = 8'b0000_0100,
		S_MARK   = 8'b0000_1000,
		S_QPOP   = 8'b0001_0000,
		S_QREAD  = 8'b0010_0000,
		S_SEEK_Q = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [EPS_W-1:0]   epsilon_q;
	logic [MINP_W-1:0]  minpts_q;
	logic [EPSQ_W-1:0]  eps_sq_q;
	logic [CNT_W-1:0]   n_q, i_q, qh_q, qt_q, count_q;
	logic [IDX_W-1:0]   hidx_q, tgt_q, q_rd_q;
	logic [PASS_W-1:0]  pass_q;
	logic [LAB_W-1:0]   cluster_q, mark_lab_q;
	logic               mark_qm_q, enq_q, inner_q, emit_on_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [IDX_W-1:0]   q_mem [MAX_POINTS];

	logic               out_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [LAB_W-1:0]   out_lab_q, out_tot_q;
	logic               out_fin_q;

	cell_t              cells [MAX_POINTS];
	cell_t              head;
	cell_mod_t          head_mod, wb_mod;
	dist_req_t          req;
	dist_res_t          res;
	logic               reg_idx, cfg_wr, accept, full, load_we;
	logic               rotate, clr_lab, clr_qm, at_i, at_tgt, head_live;
	logic               pass_end, core, push, out_free, emit_go, emit_fire, emit_done;

	// configuration
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_EPSILON: prdata = DATA_W'(epsilon_q);
			REG_MINPTS:  prdata = DATA_W'(minpts_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= EPS_W'(30);
			minpts_q  <= MINP_W'(10);
		end else if (cfg_wr) begin
			if (reg_idx == REG_EPSILON) begin
				epsilon_q <= pwdata[EPS_W-1:0];
			end else begin
				minpts_q <= pwdata[MINP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		eps_sq_q <= {{EPS_W{1'b0}}, epsilon_q} * {{EPS_W{1'b0}}, epsilon_q};
	end

	// ring of cells
	assign head    = cells[0];
	assign accept  = points.valid && points.ready;
	assign full    = (n_q == CNT_W'(MAX_POINTS));
	assign load_we = accept && !full;

	for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
		cell_mod_t m;
		assign m = (j == MAX_POINTS - 1) ? head_mod :
			(j == MAX_POINTS - 1 - LAT) ? wb_mod : '0;
		dc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rotate  (rotate),
			.nxt     (cells[(j + 1) % MAX_POINTS]),
			.mods    (m),
			.we      (load_we && (n_q[IDX_W-1:0] == IDX_W'(j))),
			.wx      (points.coord_x),
			.wy      (points.coord_y),
			.clr_lab (clr_lab),
			.clr_qm  (clr_qm),
			.st      (cells[j])
		);
	end

	// distance pipeline
	assign head_live = CNT_W'(hidx_q) < n_q;
	assign pass_end  = (pass_q == PASS_W'(MAX_POINTS + LAT));
	assign core      = CMPN_W'(count_q) >= CMPN_W'(minpts_q);

	always_comb begin
		req.elig = (state_q == S_PASS) && (pass_q < PASS_W'(MAX_POINTS)) && head_live &&
			(hidx_q != tgt_q) && (!enq_q || !head.qm);
		req.px   = px_q;
		req.py   = py_q;
		req.hx   = head.x;
		req.hy   = head.y;
		req.k    = hidx_q;
	end

	dc_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.epsilon (epsilon_q),
		.eps_sq  (eps_sq_q),
		.res     (res)
	);

	// control
	assign at_i      = (hidx_q == i_q[IDX_W-1:0]);
	assign at_tgt    = (hidx_q == tgt_q);
	assign push      = res.hit && enq_q;
	assign out_free  = !out_valid_q || labels.ready;
	assign emit_go   = emit_on_q || (hidx_q == '0);
	assign emit_fire = (state_q == S_EMIT) && emit_go && head_live && out_free;
	assign rotate    = (state_q != S_LOAD) &&
		!((state_q == S_EMIT) && emit_go && head_live && !out_free);
	assign emit_done = (state_q == S_EMIT) && emit_go && rotate &&
		(hidx_q == IDX_W'(MAX_POINTS - 1));
	assign clr_lab   = emit_done;
	assign clr_qm    = emit_done ||
		((state_q == S_PASS) && pass_end && !enq_q && !inner_q && core);
	assign points.ready = (state_q == S_LOAD);

	always_comb begin
		head_mod = '0;
		wb_mod   = '0;
		if (state_q == S_MARK && at_tgt) begin
			head_mod.set_lab = 1'b1;
			head_mod.lab     = mark_lab_q;
			head_mod.set_qm  = mark_qm_q;
		end else if (state_q == S_SEEK_Q && at_tgt &&
			(head.lab == NOISE_LAB || head.lab == UNSEEN_LAB)) begin
			head_mod.set_lab = 1'b1;
			head_mod.lab     = cluster_q;
		end
		wb_mod.set_qm = push;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[qt_q[IDX_W-1:0]] <= res.k;
		end
		q_rd_q <= q_mem[qh_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			n_q       <= '0;
			i_q       <= '0;
			qh_q      <= '0;
			qt_q      <= '0;
			count_q   <= '0;
			hidx_q    <= '0;
			tgt_q     <= '0;
			pass_q    <= '0;
			cluster_q <= '0;
			mark_lab_q <= '0;
			mark_qm_q <= 1'b0;
			enq_q     <= 1'b0;
			inner_q   <= 1'b0;
			emit_on_q <= 1'b0;
			px_q      <= '0;
			py_q      <= '0;
		end else begin
			if (rotate) begin
				hidx_q <= (hidx_q == IDX_W'(MAX_POINTS - 1)) ? '0 : hidx_q + 1'b1;
			end
			if (res.hit && !enq_q) begin
				count_q <= count_q + 1'b1;
			end
			if (push) begin
				qt_q <= qt_q + 1'b1;
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (!full) begin
							n_q <= n_q + 1'b1;
						end
						if (points.final_point) begin
							i_q     <= '0;
							state_q <= S_SEEK_I;
						end
					end
				end
				S_SEEK_I: begin
					if (i_q >= n_q) begin
						state_q <= S_EMIT;
					end else if (at_i) begin
						px_q  <= head.x;
						py_q  <= head.y;
						tgt_q <= i_q[IDX_W-1:0];
						if (head.lab != UNSEEN_LAB) begin
							i_q <= i_q + 1'b1;
						end else begin
							enq_q   <= 1'b0;
							inner_q <= 1'b0;
							pass_q  <= '0;
							count_q <= '0;
							state_q <= S_PASS;
						end
					end
				end
				S_PASS: begin
					if (!pass_end) begin
						pass_q <= pass_q + 1'b1;
					end else if (enq_q) begin
						state_q <= S_QPOP;
					end else if (!inner_q) begin
						if (core) begin
							cluster_q  <= cluster_q + 1'b1;
							mark_lab_q <= cluster_q + 1'b1;
							mark_qm_q  <= 1'b1;
							qh_q       <= '0;
							qt_q       <= '0;
						end else begin
							mark_lab_q <= NOISE_LAB;
							mark_qm_q  <= 1'b0;
						end
						state_q <= S_MARK;
					end else if (core) begin
						enq_q  <= 1'b1;
						pass_q <= '0;
					end else begin
						state_q <= S_QPOP;
					end
				end
				S_MARK: begin
					if (at_tgt) begin
						if (mark_qm_q) begin
							enq_q   <= 1'b1;
							pass_q  <= '0;
							state_q <= S_PASS;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_SEEK_I;
						end
					end
				end
				S_QPOP: begin
					if (qh_q == qt_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SEEK_I;
					end else begin
						qh_q    <= qh_q + 1'b1;
						state_q <= S_QREAD;
					end
				end
				S_QREAD: begin
					tgt_q   <= q_rd_q;
					state_q <= S_SEEK_Q;
				end
				S_SEEK_Q: begin
					if (at_tgt) begin
						px_q <= head.x;
						py_q <= head.y;
						if (head.lab == UNSEEN_LAB) begin
							enq_q   <= 1'b0;
							inner_q <= 1'b1;
							pass_q  <= '0;
							count_q <= '0;
							state_q <= S_PASS;
						end else begin
							state_q <= S_QPOP;
						end
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						emit_on_q <= 1'b1;
					end
					if (emit_done) begin
						emit_on_q <= 1'b0;
						n_q       <= '0;
						cluster_q <= '0;
						state_q   <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (labels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_idx_q <= hidx_q;
			out_lab_q <= (head.lab == NOISE_LAB) ? UNSEEN_LAB : head.lab;
			out_tot_q <= cluster_q;
			out_fin_q <= (CNT_W'(hidx_q) + CNT_W'(1)) == n_q;
		end
	end

	assign labels.valid         = out_valid_q;
	assign labels.point_index   = out_idx_q;
	assign labels.cluster_label = out_lab_q;
	assign labels.cluster_total = out_tot_q;
	assign labels.final_label   = out_fin_q;

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		qh_q <= qt_q) else $error("queue head passed tail");
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qt_q <= CNT_W'(MAX_POINTS)) else $error("queue overflow");
	a_load_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> hidx_q == '0) else $error("ring misaligned in load");
	a_hit_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		res.hit |-> state_q == S_PASS) else $error("neighbor hit outside a scan");
	a_emit_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> out_valid_q && out_idx_q == $past(hidx_q))
		else $error("label word lost");

endmodule

@@ rtl/dc_cell.sv @@
module dc_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rotate,
	input  dc_pkg::cell_t                        nxt,
	input  dc_pkg::cell_mod_t                    mods,
	input  logic                                 we,
	input  logic signed [dc_pkg::COORD_BITS-1:0] wx,
	input  logic signed [dc_pkg::COORD_BITS-1:0] wy,
	input  logic                                 clr_lab,
	input  logic                                 clr_qm,
	output dc_pkg::cell_t                        st
);
	import dc_pkg::*;

	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic [LAB_W-1:0]             lab_q;
	logic                         qm_q;
	cell_t                        cur;
	cell_t                        d;

	assign cur = {x_q, y_q, lab_q, qm_q};

	always_comb begin
		d = rotate ? nxt : cur;
		if (mods.set_lab) begin
			d.lab = mods.lab;
		end
		if (mods.set_qm) begin
			d.qm = 1'b1;
		end
		if (clr_qm) begin
			d.qm = 1'b0;
		end
		if (clr_lab) begin
			d.lab = UNSEEN_LAB;
		end
		if (we) begin
			d.x = wx;
			d.y = wy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lab_q <= UNSEEN_LAB;
			qm_q  <= 1'b0;
		end else begin
			lab_q <= d.lab;
			qm_q  <= d.qm;
		end
	end

	always_ff @(posedge clk) begin
		x_q <= d.x;
		y_q <= d.y;
	end

	assign st = cur;

endmodule

@@ rtl/dc_dist.sv @@
module dc_dist (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dc_pkg::dist_req_t           req,
	input  logic [dc_pkg::EPS_W-1:0]    epsilon,
	input  logic [dc_pkg::EPSQ_W-1:0]   eps_sq,
	output dc_pkg::dist_res_t           res
);
	import dc_pkg::*;

	logic signed [COORD_BITS:0] ddx, ddy;
	logic [COORD_BITS-1:0]      adx, ady;
	logic                       v_s1, v_s2;
	logic [COORD_BITS-1:0]      dx_s1, dy_s1;
	logic [IDX_W-1:0]           k_s1, k_s2;
	logic [SQ_W-1:0]            sqx_s2, sqy_s2;
	logic                       big_s2;
	logic [SUM_W-1:0]           sum;

	always_comb begin
		ddx = {req.px[COORD_BITS-1], req.px} - {req.hx[COORD_BITS-1], req.hx};
		ddy = {req.py[COORD_BITS-1], req.py} - {req.hy[COORD_BITS-1], req.hy};
		adx = ddx[COORD_BITS] ? COORD_BITS'(-ddx) : ddx[COORD_BITS-1:0];
		ady = ddy[COORD_BITS] ? COORD_BITS'(-ddy) : ddy[COORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.elig;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= adx;
		dy_s1  <= ady;
		k_s1   <= req.k;
		sqx_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		sqy_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		big_s2 <= (CMP_W'(dx_s1) > CMP_W'(epsilon)) || (CMP_W'(dy_s1) > CMP_W'(epsilon));
		k_s2   <= k_s1;
	end

	assign sum     = SUM_W'(sqx_s2) + SUM_W'(sqy_s2);
	assign res.hit = v_s2 && !big_s2 && (sum <= SUM_W'(eps_sq));
	assign res.k   = k_s2;

endmodule

@@ verif/dc_tb_if.sv @@
`timescale 1ns / 100ps
// interfaces come from rtl/dc_if.sv; this file carries the shared word types and register addresses
package dc_tb_pkg;
	import dc_pkg::*;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic                         fin;
	} point_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [LAB_W-1:0] lab;
		logic [LAB_W-1:0] total;
		logic             fin;
	} label_word_t;

	localparam logic [ADDR_W-1:0] ADDR_EPSILON = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_MINPTS  = 3'd4;
endpackage

@@ verif/dc_checker.sv @@
`timescale 1ns / 100ps
module dc_checker
	import dc_pkg::*;
	import dc_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	dc_point_if.sink           points,
	dc_label_if.sink           labels,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output int                 fail_count,
	output int                 pending_labels
);
	logic [EPS_W-1:0]             eps;
	logic [MINP_W-1:0]            minp;
	logic signed [COORD_BITS-1:0] xs [MAX_POINTS];
	logic signed [COORD_BITS-1:0] ys [MAX_POINTS];
	int                           npts;
	label_word_t                  label_queue [$];

	function automatic bit is_near(int a, int b);
		longint dx, dy, e;
		dx = longint'(xs[a]) - longint'(xs[b]);
		dy = longint'(ys[a]) - longint'(ys[b]);
		e = longint'(eps);
		return dx * dx + dy * dy <= e * e;
	endfunction

	function automatic int count_near(int p);
		int c;
		c = 0;
		for (int k = 0; k < npts; k++)
			if (k != p && is_near(p, k))
				c++;
		return c;
	endfunction

	task automatic cluster_set();
		int lab [MAX_POINTS];
		bit mark [MAX_POINTS];
		int q [$];
		int ncl, cur;
		label_word_t w;
		ncl = 0;
		for (int i = 0; i < npts; i++)
			lab[i] = 0;
		for (int i = 0; i < npts; i++) begin
			if (lab[i] != 0)
				continue;
			if (count_near(i) < minp) begin
				lab[i] = NOISE_LAB;
				continue;
			end
			ncl++;
			lab[i] = ncl;
			for (int k = 0; k < MAX_POINTS; k++)
				mark[k] = 0;
			mark[i] = 1;
			q.delete();
			for (int k = 0; k < npts; k++)
				if (k != i && is_near(i, k)) begin
					mark[k] = 1;
					q.insert(q.size(), k);
				end
			while (q.size() > 0) begin
				cur = q.pop_front();
				if (lab[cur] == NOISE_LAB)
					lab[cur] = ncl;
				else if (lab[cur] == 0) begin
					lab[cur] = ncl;
					if (count_near(cur) >= minp)
						for (int k = 0; k < npts; k++)
							if (k != cur && !mark[k] && is_near(cur, k)) begin
								mark[k] = 1;
								q.insert(q.size(), k);
							end
				end
			end
		end
		for (int i = 0; i < npts; i++) begin
			w.idx = IDX_W'(i);
			w.lab = (lab[i] == NOISE_LAB) ? '0 : LAB_W'(lab[i]);
			w.total = LAB_W'(ncl);
			w.fin = (i + 1 == npts);
			label_queue.insert(label_queue.size(), w);
		end
		npts = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		label_word_t e;
		if (!arst_n) begin
			eps <= 15'd30;
			minp <= 7'd10;
			npts = 0;
			fail_count = 0;
			label_queue.delete();
			pending_labels = 0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr == ADDR_EPSILON)
					eps <= pwdata[EPS_W-1:0];
				else if (paddr == ADDR_MINPTS)
					minp <= pwdata[MINP_W-1:0];
			end
			if (points.valid && points.ready) begin
				if (npts < MAX_POINTS) begin
					xs[npts] = points.coord_x;
					ys[npts] = points.coord_y;
					npts++;
				end
				if (points.final_point)
					cluster_set();
			end
			if (labels.valid && labels.ready) begin
				if (label_queue.size() == 0) begin
					$error("label word with none expected: index %0d", labels.point_index);
					fail_count++;
				end else begin
					e = label_queue.pop_front();
					if (labels.point_index !== e.idx) begin
						$error("point_index exp %0d got %0d", e.idx, labels.point_index);
						fail_count++;
					end
					if (labels.cluster_label !== e.lab) begin
						$error("cluster_label exp %0d got %0d", e.lab, labels.cluster_label);
						fail_count++;
					end
					if (labels.cluster_total !== e.total) begin
						$error("cluster_total exp %0d got %0d", e.total, labels.cluster_total);
						fail_count++;
					end
					if (labels.final_label !== e.fin) begin
						$error("final_label exp %0d got %0d", e.fin, labels.final_label);
						fail_count++;
					end
				end
			end
			pending_labels = label_queue.size();
		end
	end
endmodule

@@ verif/tb_density_clustering.sv @@
`timescale 1ns / 100ps
module tb_density_clustering;
	import dc_pkg::*;
	import dc_tb_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                fail_count, pending_labels;
	int                send_idle_pct, recv_stall_pct;
	int                hold_cycles;
	int                items_sent;

	dc_point_if points ();
	dc_label_if labels ();

	density_clustering dut (
		.clk(clk), .arst_n(arst_n), .points(points.sink), .labels(labels.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	dc_checker chk (
		.clk(clk), .arst_n(arst_n), .points(points.sink), .labels(labels.sink),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .fail_count(fail_count), .pending_labels(pending_labels)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// receiver side
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			labels.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else
			labels.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		points.valid <= 1'b0;
		while (pending_labels != 0)
			@(negedge clk);
		repeat (2 * MAX_POINTS + 8)
			@(negedge clk);
	endtask

	// drive one point; points.valid stays high if the next word follows at once
	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic fin);
		logic rdy;
		while ($urandom_range(99) < send_idle_pct) begin
			points.valid <= 1'b0;
			@(negedge clk);
		end
		points.valid <= 1'b1;
		points.coord_x <= x;
		points.coord_y <= y;
		points.final_point <= fin;
		rdy = points.ready;
		@(posedge clk);
		while (!rdy) begin
			@(negedge clk);
			rdy = points.ready;
			@(posedge clk);
		end
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_set(input int n, input int spread, input int cx, input int cy);
		int ax, ay;
		for (int i = 0; i < n; i++) begin
			ax = cx + $signed($urandom_range(2 * spread)) - spread;
			ay = cy + $signed($urandom_range(2 * spread)) - spread;
			if ($urandom_range(9) == 0) begin
				ax = $signed($urandom_range(65535)) - 32768;
				ay = $signed($urandom_range(65535)) - 32768;
			end
			if (ax > 32767) ax = 32767;
			if (ax < -32768) ax = -32768;
			if (ay > 32767) ay = 32767;
			if (ay < -32768) ay = -32768;
			send_point(16'(ax), 16'(ay), i == n - 1);
		end
	endtask

	task automatic random_phase(input int sets);
		int n, sp, c;
		for (int s = 0; s < sets; s++) begin
			n = ($urandom_range(7) == 0) ? $urandom_range(64) + 1 : $urandom_range(16) + 1;
			sp = $urandom_range(3) == 0 ? $urandom_range(2000) : $urandom_range(60);
			c = $urandom_range(3);
			send_set(n, sp, c == 0 ? 32000 : (c == 1 ? -32000 : $signed($urandom_range(2000)) - 1000),
				c == 2 ? -32000 : $signed($urandom_range(2000)) - 1000);
			if ($urandom_range(3) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		points.valid = 1'b0;
		points.coord_x = '0;
		points.coord_y = '0;
		points.final_point = 1'b0;
		labels.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		items_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, reset settings, single point, coincident points
		send_point(16'sh7fff, 16'sh7fff, 1'b0);
		send_point(-16'sh8000, -16'sh8000, 1'b0);
		send_point(16'sh7fff, -16'sh8000, 1'b0);
		send_point(16'sh0, 16'sh0, 1'b1);
		drain();
		send_point(16'sh5, 16'sh5, 1'b1);
		drain();
		reg_write(ADDR_MINPTS, 32'd0);
		reg_write(ADDR_EPSILON, 32'd0);
		send_point(16'sh10, 16'sh10, 1'b0);
		send_point(16'sh10, 16'sh10, 1'b0);
		send_point(16'sh11, 16'sh10, 1'b1);
		drain();
		reg_write(ADDR_EPSILON, 32'd32767);
		reg_write(ADDR_MINPTS, 32'd64);
		send_point(-16'sh8000, 16'sh0, 1'b0);
		send_point(16'sh7fff, 16'sh0, 1'b1);
		drain();
		reg_write(ADDR_MINPTS, 32'd1);
		send_point(-16'sh8000, 16'sh0, 1'b0);
		send_point(16'sh7fff, 16'sh0, 1'b0);
		send_point(16'sh0, 16'sh7fff, 1'b1);
		drain();
		// overfull store: 70 words, extras dropped
		reg_write(ADDR_EPSILON, 32'd30);
		reg_write(ADDR_MINPTS, 32'd3);
		send_set(70, 40, 0, 0);
		drain();

		// long receiver hold while sets keep coming
		hold_cycles = 10000;
		recv_stall_pct = 0;
		fork
			send_set(10, 30, 100, 100);
			send_set(0, 0, 0, 0);
		join
		send_set(12, 30, -100, 100);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 61 : 30) : 0;
			recv_stall_pct = (ph == 2) ? 61 : (ph == 3 ? 30 : 0);
			case (ph)
				0: begin reg_write(ADDR_EPSILON, 32'd40); reg_write(ADDR_MINPTS, 32'd3); end
				1: begin reg_write(ADDR_EPSILON, 32'd10); reg_write(ADDR_MINPTS, 32'd2); end
				2: begin reg_write(ADDR_EPSILON, 32'd100); reg_write(ADDR_MINPTS, 32'd5); end
				default: begin reg_write(ADDR_EPSILON, 32'd25); reg_write(ADDR_MINPTS, 32'd1); end
			endcase
			while (items_sent < 90 + 70 * (ph + 1))
				random_phase(1);
		end
		drain();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
